// File: rtl/core/qsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsp_pkg: shared definitions for the quarter-square primality test core
// Holds the candidate width, the payload types and the start-up constants
// of the residue walk.
// ----------------------------------------------------------------------------
package qsp_pkg;

  localparam int unsigned CandBits = 16;

  typedef logic [CandBits-1:0] cand_t;

  // Walk starts at d = 3, where floor(d*d/4) = 2 and the step floor((d+1)/2) = 2.
  localparam cand_t FirstD    = cand_t'(3);
  localparam cand_t FirstRes  = cand_t'(2);
  localparam cand_t FirstHalf = cand_t'(2);
  localparam cand_t SmallestOdd = cand_t'(3);
  localparam cand_t OnlyEven    = cand_t'(2);

endpackage

// File: rtl/core/qsp_cand_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsp_cand_if: candidate channel
// Valid/ready channel that carries one candidate word.
// ----------------------------------------------------------------------------
interface qsp_cand_if
  import qsp_pkg::*;
  ();
  logic  valid;
  logic  ready;
  cand_t candidate;

  modport source (output valid, output candidate, input ready);
  modport sink   (input valid, input candidate, output ready);
endinterface

// File: rtl/core/qsp_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsp_res_if: result channel
// Valid/ready channel that carries one primality verdict word.
// ----------------------------------------------------------------------------
interface qsp_res_if;
  logic valid;
  logic ready;
  logic is_prime;

  modport source (output valid, output is_prime, input ready);
  modport sink   (input valid, input is_prime, output ready);
endinterface

// File: rtl/core/quarter_square_primality_test_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quarter_square_primality_test_core: sequential primality tester
// Decides whether a candidate is prime by a search over quarter squares,
// one step of a shared add/compare/subtract unit per clock.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload            Handshake
//  -------   ---------  -----------------  -----------------------
//  cand_i    in         candidate [15:0]   valid/ready, sink
//  res_o     out        is_prime  [0]      valid/ready, source
//
// A candidate word is taken only while the sequencer is idle. Zero, one, two,
// three and even values go straight to the hold state. An odd candidate n of
// five or more walks d = 3 .. n-1 at one step per cycle, stopping at a hit.
// Reset clears the sequencer and the output valid flag; no data is cleared.
// A stalled result word is held in the output register while the next
// candidate is taken and tested; a finished verdict waits only if the
// previous one has still not been taken.
//
// The test: with d = n - j, (d*d + 3 + (j mod 2)) / 4 rounded down equals
// floor(d*d/4) + 1 for odd n, so a hit means floor(d*d/4) is a multiple of
// n. The residue r = floor(d*d/4) mod n grows by floor((d+1)/2) from one d to
// the next, which is always below n, so one conditional subtraction keeps r
// reduced. Walking d upwards rather than downwards gives the same verdict,
// since only whether any hit exists matters.
// ----------------------------------------------------------------------------
module quarter_square_primality_test_core
  import qsp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  qsp_cand_if.sink     cand_i,
  qsp_res_if.source    res_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StHold = 2'd2;

  logic [1:0] state_q, state_d;

  // Working registers of the walk.
  cand_t n_q, n_d;        // candidate under test
  cand_t d_q, d_d;        // current d
  cand_t r_q, r_d;        // floor(d*d/4) mod n
  cand_t h_q, h_d;        // floor((d+1)/2), the increment to the next d
  logic  verdict_q, verdict_d;

  logic  out_valid_q, out_valid_d;
  logic  out_prime_q, out_prime_d;

  // Shared unit: one add, one compare, one subtract. The subtraction is
  // only used when the sum is at least n, so its low bits are exact.
  logic [CandBits:0]   sum;
  logic [CandBits-1:0] diff;
  logic                wrap;

  assign sum  = {1'b0, r_q} + {1'b0, h_q};
  assign diff = sum[CandBits-1:0] - n_q;
  assign wrap = (sum >= {1'b0, n_q});

  logic in_take;
  logic out_free;

  assign cand_i.ready = (state_q == StIdle);
  assign in_take      = cand_i.valid && cand_i.ready;
  assign out_free     = !out_valid_q || res_o.ready;

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    d_d         = d_q;
    r_d         = r_q;
    h_d         = h_q;
    verdict_d   = verdict_q;
    out_valid_d = out_valid_q;
    out_prime_d = out_prime_q;

    if (out_valid_q && res_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_take) begin
          n_d = cand_i.candidate;
          d_d = FirstD;
          r_d = FirstRes;
          h_d = FirstHalf;
          if (cand_i.candidate == OnlyEven || cand_i.candidate == SmallestOdd) begin
            // Both have an empty search range.
            verdict_d = 1'b1;
            state_d   = StHold;
          end else if (cand_i.candidate < OnlyEven || !cand_i.candidate[0]) begin
            verdict_d = 1'b0;
            state_d   = StHold;
          end else begin
            state_d = StRun;
          end
        end
      end
      StRun: begin
        if (r_q == '0) begin
          verdict_d = 1'b0;
          state_d   = StHold;
        end else if (d_q == n_q - cand_t'(1)) begin
          verdict_d = 1'b1;
          state_d   = StHold;
        end else begin
          r_d = wrap ? diff : sum[CandBits-1:0];
          d_d = d_q + cand_t'(1);
          h_d = h_q + cand_t'(!d_q[0]);
        end
      end
      StHold: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_prime_d = verdict_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q         <= n_d;
    d_q         <= d_d;
    r_q         <= r_d;
    h_q         <= h_d;
    verdict_q   <= verdict_d;
    out_prime_q <= out_prime_d;
  end

  assign res_o.valid    = out_valid_q;
  assign res_o.is_prime = out_prime_q;

endmodule
